// ===== rtl/core/tms_pkg.sv =====
// tms_pkg: shared constants and controller/datapath interface types
// for trajectory_median_split; no dependencies
`timescale 1ns / 1ps

package tms_pkg;

	localparam int MAX_TRAJ_DEF  = 32;
	localparam int MAX_SLOTS_DEF = 64;
	localparam int RESULT_CAP    = 32;

	localparam int SLOT_W  = 6;
	localparam int TIME_W  = 31;
	localparam int INDEX_W = 5;

	// per-slot statistics word: valid, min start, max end, grid id
	localparam int STAT_W = 1 + 3 * TIME_W;

	typedef struct packed {
		logic accept;
		logic upd;
		logic sel_init;
		logic sel_run;
		logic med_init;
		logic med_ri;
		logic med_ci;
		logic med_j;
		logic med_next;
		logic em_init;
		logic em_run;
		logic clr_init;
		logic clr_run;
	} cmd_t;

	typedef struct packed {
		logic rec_es;
		logic sel_done;
		logic found;
		logic n_zero;
		logic med_j_done;
		logic med_hit;
		logic em_done;
		logic clr_done;
	} sts_t;

endpackage

// ===== rtl/core/tms_ram.sv =====
// tms_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module tms_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic                                 re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/tms_ctrl.sv =====
// tms_ctrl: sequencing state machine for load, slot selection, median
// search, result emission and table clearing; depends on tms_pkg
`timescale 1ns / 1ps

module tms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tms_pkg::sts_t sts,
	output tms_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_UPD  = 9'b000000100,
		ST_SEL  = 9'b000001000,
		ST_MRI  = 9'b000010000,
		ST_MCI  = 9'b000100000,
		ST_MJ   = 9'b001000000,
		ST_MCK  = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (sts.rec_es) begin
					cmd.sel_init = 1'b1;
					state_d      = ST_SEL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEL: begin
				cmd.sel_run = 1'b1;
				if (sts.sel_done) begin
					if (sts.found && !sts.n_zero) begin
						cmd.med_init = 1'b1;
						state_d      = ST_MRI;
					end else begin
						cmd.em_init = 1'b1;
						state_d     = ST_EMIT;
					end
				end
			end
			ST_MRI: begin
				cmd.med_ri = 1'b1;
				state_d    = ST_MCI;
			end
			ST_MCI: begin
				cmd.med_ci = 1'b1;
				state_d    = ST_MJ;
			end
			ST_MJ: begin
				cmd.med_j = 1'b1;
				if (sts.med_j_done) state_d = ST_MCK;
			end
			ST_MCK: begin
				if (sts.med_hit) begin
					cmd.em_init = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.med_next = 1'b1;
					state_d      = ST_MRI;
				end
			end
			ST_EMIT: begin
				cmd.em_run = 1'b1;
				if (sts.em_done) begin
					cmd.clr_init = 1'b1;
					state_d      = ST_CLR;
				end
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/tms_dp.sv =====
// tms_dp: record capture, slot statistics and end-time memories, range
// selection, median rank search and result registers; depends on tms_pkg, tms_ram
`timescale 1ns / 1ps

module tms_dp #(
	parameter int MAX_TRAJ  = tms_pkg::MAX_TRAJ_DEF,
	parameter int MAX_SLOTS = tms_pkg::MAX_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tms_pkg::cmd_t                cmd,
	output tms_pkg::sts_t                sts,
	input  logic [tms_pkg::SLOT_W-1:0]   slot,
	input  logic [tms_pkg::TIME_W-1:0]   grid_id,
	input  logic [tms_pkg::TIME_W-1:0]   start_time,
	input  logic [tms_pkg::TIME_W-1:0]   exit_time,
	input  logic                         last_in_traj,
	input  logic                         last_in_set,
	output logic                         strobe,
	output logic [tms_pkg::INDEX_W-1:0]  traj_index,
	output logic                         side,
	output logic [tms_pkg::TIME_W-1:0]   chosen_grid,
	output logic                         chosen_found,
	output logic [tms_pkg::TIME_W-1:0]   split_time,
	output logic                         overflow,
	output logic                         last
);

	localparam int TW  = $clog2(MAX_TRAJ + 1);
	localparam int SCW = $clog2(MAX_SLOTS + 1);
	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int ED  = MAX_TRAJ * MAX_SLOTS;
	localparam int AW  = $clog2(ED);
	localparam int TMW = tms_pkg::TIME_W;

	// captured record
	logic [tms_pkg::SLOT_W-1:0] rec_slot_q;
	logic [TMW-1:0]             rec_gid_q, rec_st_q, rec_en_q;
	logic                       rec_et_q, rec_es_q;

	logic [TW-1:0]  traj_cnt_q;
	logic [SCW-1:0] slot_cnt_q;
	logic           ovf_q;

	// selection
	logic [SCW-1:0]       sel_a_q;
	logic                 sel_v_s1;
	logic [SW-1:0]        sel_idx_s1;
	logic signed [TMW:0]  best_q;
	logic [SW-1:0]        chosen_q;
	logic [TMW-1:0]       grid_q;
	logic                 found_q;

	// median rank search
	logic [TW-1:0]  med_i_q, med_j_q, lt_q, le_q;
	logic           jv_s1;
	logic [TMW-1:0] vi_q, median_q;

	// emission
	logic [TW-1:0] em_i_q, em_idx_s1;
	logic          em_v_s1;

	// clearing
	logic [SCW-1:0] clr_a_q, clr_lim_q;

	// memories
	logic                       st_we, st_re;
	logic [SW-1:0]              st_waddr, st_raddr;
	logic [tms_pkg::STAT_W-1:0] st_wdata, st_rdata;
	logic                       en_we, en_re;
	logic [AW-1:0]              en_waddr, en_raddr;
	logic [TMW-1:0]             en_rdata;

	logic                 r_valid;
	logic [TMW-1:0]       r_min, r_max, r_gid;
	logic                 drop;
	logic signed [TMW:0]  range;
	logic                 sel_issue, mj_issue, em_issue;
	logic [TW-1:0]        rd_idx, emit_n, k;
	logic [SCW-1:0]       slot_p1;

	assign {r_valid, r_min, r_max, r_gid} = st_rdata;

	assign drop = (32'(traj_cnt_q) >= 32'(MAX_TRAJ)) ||
		(32'(rec_slot_q) >= 32'(MAX_SLOTS));
	assign range = $signed({1'b0, r_max}) - $signed({1'b0, r_min});
	assign slot_p1 = SCW'(32'(rec_slot_q) + 32'd1);

	assign emit_n = (32'(traj_cnt_q) < 32'(tms_pkg::RESULT_CAP)) ? traj_cnt_q :
		TW'(tms_pkg::RESULT_CAP);
	assign k = traj_cnt_q >> 1;

	assign sel_issue = cmd.sel_run && (sel_a_q < slot_cnt_q);
	assign mj_issue  = cmd.med_j && (med_j_q < traj_cnt_q);
	assign em_issue  = cmd.em_run && (em_i_q < emit_n);

	// statistics memory
	assign st_re    = cmd.accept || sel_issue;
	assign st_raddr = cmd.accept ? SW'(slot) : sel_a_q[SW-1:0];
	assign st_we    = (cmd.upd && !drop) || (cmd.clr_run && (clr_a_q < clr_lim_q));
	assign st_waddr = cmd.upd ? SW'(rec_slot_q) : clr_a_q[SW-1:0];
	always_comb begin
		if (!cmd.upd) begin
			st_wdata = '0;
		end else if (r_valid) begin
			st_wdata = {1'b1, (rec_st_q < r_min) ? rec_st_q : r_min,
				(rec_en_q > r_max) ? rec_en_q : r_max, r_gid};
		end else begin
			st_wdata = {1'b1, rec_st_q, rec_en_q, rec_gid_q};
		end
	end

	// end-time memory, row per trajectory
	assign en_we    = cmd.upd && !drop;
	assign en_waddr = AW'(32'(traj_cnt_q) * 32'(MAX_SLOTS) + 32'(rec_slot_q));
	assign en_re    = cmd.med_ri || mj_issue || em_issue;
	assign rd_idx   = cmd.med_ri ? med_i_q : (cmd.med_j ? med_j_q : em_i_q);
	assign en_raddr = AW'(32'(rd_idx) * 32'(MAX_SLOTS) + 32'(chosen_q));

	tms_ram #(.W(tms_pkg::STAT_W), .D(MAX_SLOTS)) u_stat_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	tms_ram #(.W(TMW), .D(ED)) u_end_ram (
		.clk   (clk),
		.we    (en_we),
		.waddr (en_waddr),
		.wdata (rec_en_q),
		.re    (en_re),
		.raddr (en_raddr),
		.rdata (en_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			traj_cnt_q <= '0;
			slot_cnt_q <= '0;
			ovf_q      <= 1'b0;
			sel_a_q    <= '0;
			sel_v_s1   <= 1'b0;
			found_q    <= 1'b0;
			med_i_q    <= '0;
			med_j_q    <= '0;
			jv_s1      <= 1'b0;
			em_i_q     <= '0;
			em_v_s1    <= 1'b0;
			strobe     <= 1'b0;
			clr_a_q    <= '0;
			clr_lim_q  <= SCW'(MAX_SLOTS);
		end else begin
			if (cmd.upd) begin
				if (drop) begin
					ovf_q <= 1'b1;
				end else begin
					if (slot_p1 > slot_cnt_q) slot_cnt_q <= slot_p1;
					if (rec_et_q || rec_es_q) traj_cnt_q <= traj_cnt_q + TW'(1);
				end
			end
			if (cmd.sel_init) begin
				sel_a_q  <= '0;
				sel_v_s1 <= 1'b0;
				found_q  <= 1'b0;
			end
			if (cmd.sel_run) begin
				sel_v_s1 <= sel_issue;
				if (sel_issue) sel_a_q <= sel_a_q + SCW'(1);
				if (sel_v_s1 && r_valid && (range > best_q)) found_q <= 1'b1;
			end
			if (cmd.med_init) med_i_q <= '0;
			if (cmd.med_next) med_i_q <= med_i_q + TW'(1);
			if (cmd.med_ci) begin
				med_j_q <= '0;
				jv_s1   <= 1'b0;
			end
			if (cmd.med_j) begin
				jv_s1 <= mj_issue;
				if (mj_issue) med_j_q <= med_j_q + TW'(1);
			end
			if (cmd.em_init) begin
				em_i_q  <= '0;
				em_v_s1 <= 1'b0;
			end
			if (cmd.em_run) begin
				em_v_s1 <= em_issue;
				if (em_issue) em_i_q <= em_i_q + TW'(1);
			end
			strobe <= em_v_s1;
			if (cmd.clr_init) begin
				clr_a_q    <= '0;
				clr_lim_q  <= slot_cnt_q;
				traj_cnt_q <= '0;
				slot_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end
			if (cmd.clr_run && (clr_a_q < clr_lim_q)) clr_a_q <= clr_a_q + SCW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rec_slot_q <= slot;
			rec_gid_q  <= grid_id;
			rec_st_q   <= start_time;
			rec_en_q   <= exit_time;
			rec_et_q   <= last_in_traj;
			rec_es_q   <= last_in_set;
		end
		if (cmd.sel_init) begin
			best_q   <= '0;
			chosen_q <= '0;
			grid_q   <= '0;
			median_q <= '0;
		end
		sel_idx_s1 <= sel_a_q[SW-1:0];
		if (cmd.sel_run && sel_v_s1 && r_valid && (range > best_q)) begin
			best_q   <= range;
			chosen_q <= sel_idx_s1;
			grid_q   <= r_gid;
		end
		if (cmd.med_ci) begin
			vi_q <= en_rdata;
			lt_q <= '0;
			le_q <= '0;
		end
		if (cmd.med_j && jv_s1) begin
			if (en_rdata < vi_q)  lt_q <= lt_q + TW'(1);
			if (en_rdata <= vi_q) le_q <= le_q + TW'(1);
		end
		if (cmd.em_init && sts.med_hit && !cmd.sel_run) median_q <= vi_q;
		em_idx_s1 <= em_i_q;
		if (em_v_s1) begin
			traj_index   <= tms_pkg::INDEX_W'(em_idx_s1);
			side         <= found_q ? (en_rdata >= median_q) : 1'b1;
			chosen_grid  <= grid_q;
			chosen_found <= found_q;
			split_time   <= median_q;
			overflow     <= ovf_q;
			last         <= ((em_idx_s1 + TW'(1)) == emit_n);
		end
	end

	assign sts.rec_es     = rec_es_q;
	assign sts.sel_done   = (sel_a_q == slot_cnt_q) && !sel_v_s1;
	assign sts.found      = found_q;
	assign sts.n_zero     = (traj_cnt_q == '0);
	assign sts.med_j_done = (med_j_q == traj_cnt_q) && !jv_s1;
	assign sts.med_hit    = (lt_q <= k) && (k < le_q);
	assign sts.em_done    = (em_i_q == emit_n) && !em_v_s1;
	assign sts.clr_done   = (clr_a_q == clr_lim_q);

endmodule

// ===== rtl/core/trajectory_median_split.sv =====
// trajectory_median_split: top level, controller plus datapath
// depends on tms_pkg, tms_ctrl, tms_dp
//
// records enter on start when busy is low, one per request; each goes
// through a statistics read, then a read-modify-write of the slot table
// the record with last_in_set starts the split: a walk over the slot table,
// then, if a slot with a positive range was found, a rank search for the
// upper median over the end-time memory, n trajectories stored
// then min(n,32) results, one per cycle on strobe, in load order, the
// final one with last; no result if no trajectory was stored
// the receiver cannot stall: every result is shown for exactly one cycle
// after the results the first slot_count entries of the slot table are cleared
// busy stays high from a request until the block can take the next one
// reset clears the control counters and runs a clearing pass over MAX_SLOTS
// entries of the slot table before busy falls
`timescale 1ns / 1ps

module trajectory_median_split #(
	parameter int MAX_TRAJ  = tms_pkg::MAX_TRAJ_DEF,
	parameter int MAX_SLOTS = tms_pkg::MAX_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tms_pkg::SLOT_W-1:0]  slot,
	input  logic [tms_pkg::TIME_W-1:0]  grid_id,
	input  logic [tms_pkg::TIME_W-1:0]  start_time,
	input  logic [tms_pkg::TIME_W-1:0]  exit_time,
	input  logic                        last_in_traj,
	input  logic                        last_in_set,
	output logic                        strobe,
	output logic [tms_pkg::INDEX_W-1:0] traj_index,
	output logic                        side,
	output logic [tms_pkg::TIME_W-1:0]  chosen_grid,
	output logic                        chosen_found,
	output logic [tms_pkg::TIME_W-1:0]  split_time,
	output logic                        overflow,
	output logic                        last
);

	tms_pkg::cmd_t cmd;
	tms_pkg::sts_t sts;

	tms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tms_dp #(.MAX_TRAJ(MAX_TRAJ), .MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.slot         (slot),
		.grid_id      (grid_id),
		.start_time   (start_time),
		.exit_time    (exit_time),
		.last_in_traj (last_in_traj),
		.last_in_set  (last_in_set),
		.strobe       (strobe),
		.traj_index   (traj_index),
		.side         (side),
		.chosen_grid  (chosen_grid),
		.chosen_found (chosen_found),
		.split_time   (split_time),
		.overflow     (overflow),
		.last         (last)
	);

endmodule

// ===== rtl/core/tms_checker.sv =====
// tms_checker: port-level assertions for trajectory_median_split and its bind
// depends on tms_pkg, trajectory_median_split
`timescale 1ns / 1ps

module tms_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        strobe,
	input logic [tms_pkg::INDEX_W-1:0] traj_index,
	input logic                        side,
	input logic                        chosen_found,
	input logic                        last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without busy");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result outside a run");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result after last");

	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (traj_index == $past(traj_index) + 5'd1))
		else $error("results not contiguous");

	a_side_found: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !side |-> chosen_found)
		else $error("side 0 without split");

endmodule

bind trajectory_median_split tms_checker u_tms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.traj_index   (traj_index),
	.side         (side),
	.chosen_found (chosen_found),
	.last         (last)
);

// ===== tb/tms_checker.sv =====
// tms_scoreboard: watches the request and result channels of trajectory_median_split,
// predicts the side of each of the first RESULT_CAP trajectories per set and compares field by field
// depends on tms_pkg for field widths and capacities
`timescale 1ns / 1ps

module tms_scoreboard (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [tms_pkg::SLOT_W-1:0]  slot,
	input  logic [tms_pkg::TIME_W-1:0]  grid_id,
	input  logic [tms_pkg::TIME_W-1:0]  start_time,
	input  logic [tms_pkg::TIME_W-1:0]  exit_time,
	input  logic                        last_in_traj,
	input  logic                        last_in_set,
	input  logic                        strobe,
	input  logic [tms_pkg::INDEX_W-1:0] traj_index,
	input  logic                        side,
	input  logic [tms_pkg::TIME_W-1:0]  chosen_grid,
	input  logic                        chosen_found,
	input  logic [tms_pkg::TIME_W-1:0]  split_time,
	input  logic                        overflow,
	input  logic                        last,
	output int                          errors,
	output int                          pending
);

	localparam int NTRAJ  = tms_pkg::MAX_TRAJ_DEF;
	localparam int NSLOT  = tms_pkg::MAX_SLOTS_DEF;
	localparam int IW     = tms_pkg::INDEX_W;
	localparam int TW     = tms_pkg::TIME_W;
	localparam int CAP    = tms_pkg::RESULT_CAP;
	localparam int QDEPTH = 64;

	typedef struct {
		logic [IW-1:0] idx;
		logic          sd;
		logic [TW-1:0] grid;
		logic          found;
		logic [TW-1:0] split;
		logic          ovf;
		logic          fin;
	} side_t;

	side_t          exp_fifo[QDEPTH];
	int             wr_ptr;
	int             rd_ptr;
	logic [TW-1:0]  ends[NTRAJ][NSLOT];
	logic [TW-1:0]  min_start[NSLOT];
	logic [TW-1:0]  max_end[NSLOT];
	logic [TW-1:0]  slot_grid[NSLOT];
	bit             seen[NSLOT];
	int             n_traj;
	int             n_slot;
	bit             dropped;

	assign pending = wr_ptr - rd_ptr;

	initial begin
		errors = 0;
		wr_ptr = 0;
		rd_ptr = 0;
		n_traj = 0;
		n_slot = 0;
		dropped = 0;
		foreach (seen[i]) seen[i] = 0;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic predict_split();
		logic [TW-1:0] vals[NTRAJ];
		logic [TW-1:0] v;
		logic [TW-1:0] med;
		longint        best;
		longint        rng;
		int            pick;
		int            j;
		int            cnt;
		bit            found;
		side_t         r;
		best = 0;
		pick = 0;
		found = 0;
		med = '0;
		for (int s = 0; s < n_slot; s++) begin
			if (seen[s]) begin
				rng = longint'(max_end[s]) - longint'(min_start[s]);
				if (rng > best) begin
					best = rng;
					pick = s;
					found = 1;
				end
			end
		end
		if (found && n_traj > 0) begin
			for (int i = 0; i < n_traj; i++) vals[i] = ends[i][pick];
			for (int i = 1; i < n_traj; i++) begin
				v = vals[i];
				j = i;
				while (j > 0 && vals[j-1] > v) begin
					vals[j] = vals[j-1];
					j--;
				end
				vals[j] = v;
			end
			med = vals[n_traj/2];
		end
		cnt = n_traj < CAP ? n_traj : CAP;
		for (int i = 0; i < cnt; i++) begin
			r.idx = i[IW-1:0];
			r.sd = found ? (ends[i][pick] >= med) : 1'b1;
			r.grid = found ? slot_grid[pick] : '0;
			r.found = found;
			r.split = med;
			r.ovf = dropped;
			r.fin = (i + 1 == cnt);
			exp_fifo[wr_ptr % QDEPTH] = r;
			wr_ptr++;
		end
		foreach (seen[i]) seen[i] = 0;
		n_traj = 0;
		n_slot = 0;
		dropped = 0;
	endtask

	always @(posedge clk) begin
		side_t e;
		if (arst_n && start && !busy) begin
			if (n_traj >= NTRAJ) begin
				dropped = 1;
			end else begin
				ends[n_traj][slot] = exit_time;
				if (!seen[slot]) begin
					seen[slot] = 1;
					min_start[slot] = start_time;
					max_end[slot] = exit_time;
					slot_grid[slot] = grid_id;
				end else begin
					if (start_time < min_start[slot]) min_start[slot] = start_time;
					if (exit_time > max_end[slot]) max_end[slot] = exit_time;
				end
				if (int'(slot) + 1 > n_slot) n_slot = int'(slot) + 1;
				if (last_in_traj || last_in_set) n_traj++;
			end
			if (last_in_set) predict_split();
		end
		if (arst_n && strobe) begin
			if (wr_ptr == rd_ptr) begin
				report($sformatf("unexpected result for trajectory %0d", traj_index));
			end else begin
				e = exp_fifo[rd_ptr % QDEPTH];
				rd_ptr++;
				if (traj_index !== e.idx)
					report($sformatf("traj_index %0d, want %0d", traj_index, e.idx));
				if (side !== e.sd)
					report($sformatf("side %b, want %b (traj %0d)", side, e.sd, e.idx));
				if (chosen_grid !== e.grid)
					report($sformatf("chosen_grid %0h, want %0h", chosen_grid, e.grid));
				if (chosen_found !== e.found)
					report($sformatf("chosen_found %b, want %b", chosen_found, e.found));
				if (split_time !== e.split)
					report($sformatf("split_time %0h, want %0h", split_time, e.split));
				if (overflow !== e.ovf)
					report($sformatf("overflow %b, want %b", overflow, e.ovf));
				if (last !== e.fin)
					report($sformatf("last %b, want %b (traj %0d)", last, e.fin, e.idx));
			end
		end
	end

endmodule

// ===== tb/trajectory_median_split_tb.sv =====
// trajectory_median_split_tb: drives record sets into trajectory_median_split
// under several idle patterns; tms_scoreboard predicts and compares the sides
// depends on tms_pkg, trajectory_median_split, tms_scoreboard
`timescale 1ns / 1ps

module trajectory_median_split_tb;

	localparam int     SW    = tms_pkg::SLOT_W;
	localparam int     TW    = tms_pkg::TIME_W;
	localparam int     IW    = tms_pkg::INDEX_W;
	localparam longint LIMIT = 3000000;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          start = 0;
	logic          busy;
	logic [SW-1:0] slot = '0;
	logic [TW-1:0] grid_id = '0;
	logic [TW-1:0] start_time = '0;
	logic [TW-1:0] exit_time = '0;
	logic          last_in_traj = 0;
	logic          last_in_set = 0;
	logic          strobe;
	logic [IW-1:0] traj_index;
	logic          side;
	logic [TW-1:0] chosen_grid;
	logic          chosen_found;
	logic [TW-1:0] split_time;
	logic          overflow;
	logic          last;
	int            errors;
	int            pending;
	longint        cycles = 0;
	int            idle_pct = 0;
	int            sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	trajectory_median_split u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .slot(slot),
		.grid_id(grid_id), .start_time(start_time), .exit_time(exit_time),
		.last_in_traj(last_in_traj), .last_in_set(last_in_set), .strobe(strobe),
		.traj_index(traj_index), .side(side), .chosen_grid(chosen_grid),
		.chosen_found(chosen_found), .split_time(split_time), .overflow(overflow),
		.last(last)
	);

	tms_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .slot(slot),
		.grid_id(grid_id), .start_time(start_time), .exit_time(exit_time),
		.last_in_traj(last_in_traj), .last_in_set(last_in_set), .strobe(strobe),
		.traj_index(traj_index), .side(side), .chosen_grid(chosen_grid),
		.chosen_found(chosen_found), .split_time(split_time), .overflow(overflow),
		.last(last), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [TW-1:0] rand_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return TW'($urandom_range(0, 15));
			4: return TW'(31'h7FFF_FFF0 + $urandom_range(0, 15));
			default: return TW'($urandom());
		endcase
	endfunction

	task automatic send_record(input logic [SW-1:0] s, input logic [TW-1:0] g,
			input logic [TW-1:0] st, input logic [TW-1:0] en,
			input logic lt, input logic ls);
		int gap;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		slot <= s;
		grid_id <= g;
		start_time <= st;
		exit_time <= en;
		last_in_traj <= lt;
		last_in_set <= ls;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// every trajectory carries the same slot list so no unwritten end time is read
	task automatic run_set(input int n, input int slots[$], input bit drop_lt);
		logic lt;
		for (int t = 0; t < n; t++) begin
			foreach (slots[k]) begin
				lt = (k == slots.size() - 1);
				if (t == n - 1 && lt && drop_lt) lt = 0;
				send_record(SW'(slots[k]), TW'($urandom()), rand_time(),
					rand_time(), lt, (t == n - 1) && (k == slots.size() - 1));
			end
		end
	endtask

	task automatic random_slots(output int slots[$], input int maxn);
		int s;
		slots = {};
		s = $urandom_range(0, 3);
		while (s < 64 && slots.size() < maxn) begin
			slots = {slots, s};
			s += $urandom_range(1, 20);
		end
	endtask

	initial begin
		int sl[$];
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// widest range at slot 0
		send_record(6'd0, '1, '0, '1, 1'b1, 1'b1);
		// no positive range: every side is 1
		send_record(6'd5, 31'h55, 31'h100, 31'h100, 1'b1, 1'b0);
		send_record(6'd5, 31'h66, '1, 31'h10, 1'b1, 1'b1);
		// equal ranges: the first slot wins, ties with the median
		send_record(6'd0, 31'h2AAA_AAAA, 31'd10, 31'd20, 1'b0, 1'b0);
		send_record(6'd63, 31'h5555_5555, 31'd10, 31'd20, 1'b1, 1'b0);
		send_record(6'd0, 31'h1, 31'd10, 31'd20, 1'b0, 1'b0);
		send_record(6'd63, 31'h2, 31'd10, 31'd20, 1'b1, 1'b0);
		send_record(6'd0, 31'h3, 31'd15, 31'd15, 1'b0, 1'b0);
		// set end without trajectory end
		send_record(6'd63, 31'h4, 31'd12, 31'd12, 1'b0, 1'b1);
		sl = {1, 2};
		run_set(3, sl, 1'b1);
		while (sent < 350) begin
			case (sent * 4 / 350)
				0: idle_pct = 0;
				1: idle_pct = 58;
				2: idle_pct = 13;
				default: idle_pct = 58;
			endcase
			if ($urandom_range(0, 11) == 0) begin
				// more trajectories than capacity, one slot each
				sl = {int'($urandom_range(0, 63))};
				run_set(int'($urandom_range(33, 35)), sl, 1'($urandom_range(0, 1)));
			end else begin
				random_slots(sl, int'($urandom_range(1, 4)));
				n = int'($urandom_range(1, 7));
				run_set(n, sl, $urandom_range(0, 3) == 0);
			end
		end
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/tms_pkg.sv
rtl/core/tms_ram.sv
rtl/core/tms_ctrl.sv
rtl/core/tms_dp.sv
rtl/core/trajectory_median_split.sv
rtl/core/tms_checker.sv
tb/tms_checker.sv
tb/trajectory_median_split_tb.sv
